@@ rtl/core/cfhash_pkg.sv @@
// Package with shared types, constants and hash functions for the case-folded hash unit.
`default_nettype none

package cfhash_pkg;

    // Command queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Result buffer geometry.
    localparam int O_DEPTH = 2;
    localparam int O_PTR_W = $clog2(O_DEPTH);
    localparam int O_CNT_W = O_PTR_W + 1;

    // Command operation codes.
    localparam logic OP_MIX = 1'b0;
    localparam logic OP_FIN = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // One request passed from the front end to the back end.
    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } cmd_t;

    // Mix one (already folded) byte into the running hash.
    function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] s1;
        logic [31:0] s2;
        s1 = h + {{24{b[7]}}, b};
        s2 = s1 + (s1 << 10);
        return s2 ^ (s2 >> 6);
    endfunction

    // Final avalanche.
    function automatic logic [31:0] finish_hash(input logic [31:0] h);
        logic [31:0] s1;
        logic [31:0] s2;
        s1 = h + (h << 3);
        s2 = s1 ^ (s1 >> 11);
        return s2 + (s2 << 15);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cfhash_front.sv @@
// Front end: accepts path bytes, folds case and tracks quoting, issues mix or finish commands.
`default_nettype none

module cfhash_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [7:0]        char_byte,
    input  wire logic              q_full,
    output logic                   q_push,
    output cfhash_pkg::cmd_t       q_cmd
);

    logic first_reg;
    logic first_next;
    logic quoted_reg;
    logic quoted_next;
    logic stopped_reg;
    logic stopped_next;
    logic accept;
    logic is_quote;
    logic [7:0] folded;

    assign accept   = push && !q_full;
    assign is_quote = (char_byte == cfhash_pkg::CH_QUOTE);

    always_comb
    begin
        if (char_byte >= cfhash_pkg::CH_UPPER_A && char_byte <= cfhash_pkg::CH_UPPER_Z)
        begin
            folded = char_byte + cfhash_pkg::CASE_OFFSET;
        end
        else if (char_byte == cfhash_pkg::CH_BACKSLASH)
        begin
            folded = cfhash_pkg::CH_SLASH;
        end
        else
        begin
            folded = char_byte;
        end
    end

    always_comb
    begin
        first_next   = first_reg;
        quoted_next  = quoted_reg;
        stopped_next = stopped_reg;
        q_push       = 1'b0;
        q_cmd.op     = cfhash_pkg::OP_MIX;
        q_cmd.data   = folded;
        if (accept)
        begin
            if (char_byte == cfhash_pkg::CH_NUL)
            begin
                // The terminator finishes the string and rearms the start state.
                q_push       = 1'b1;
                q_cmd.op     = cfhash_pkg::OP_FIN;
                first_next   = 1'b1;
                quoted_next  = 1'b0;
                stopped_next = 1'b0;
            end
            else if (first_reg)
            begin
                first_next = 1'b0;
                if (is_quote)
                begin
                    quoted_next = 1'b1;
                end
                else
                begin
                    q_push = 1'b1;
                end
            end
            else if (stopped_reg)
            begin
                q_push = 1'b0;
            end
            else if (quoted_reg && is_quote)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg   <= 1'b1;
            quoted_reg  <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            first_reg   <= first_next;
            quoted_reg  <= quoted_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cfhash_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none

module cfhash_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_push,
    input  wire cfhash_pkg::cmd_t  q_in,
    output logic                   q_full,
    input  wire logic              q_pop,
    output cfhash_pkg::cmd_t       q_out,
    output logic                   q_empty
);

    cfhash_pkg::cmd_t mem_reg [cfhash_pkg::Q_DEPTH];
    logic [cfhash_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [cfhash_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [cfhash_pkg::Q_CNT_W-1:0] cnt_reg;
    logic [cfhash_pkg::Q_CNT_W-1:0] cnt_next;
    logic do_push;
    logic do_pop;

    assign q_full  = (cnt_reg == cfhash_pkg::Q_CNT_W'(cfhash_pkg::Q_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_out   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + cfhash_pkg::Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - cfhash_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + cfhash_pkg::Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + cfhash_pkg::Q_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cfhash_back.sv @@
// Back end: running hash, finalization and the result buffer.
`default_nettype none

module cfhash_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfhash_pkg::cmd_t  q_out,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output logic [31:0]            hash_value
);

    logic [31:0] hash_reg;
    logic [31:0] obuf_reg [cfhash_pkg::O_DEPTH];
    logic [cfhash_pkg::O_PTR_W-1:0] o_wr_reg;
    logic [cfhash_pkg::O_PTR_W-1:0] o_rd_reg;
    logic [cfhash_pkg::O_CNT_W-1:0] o_cnt_reg;
    logic [cfhash_pkg::O_CNT_W-1:0] o_cnt_next;
    logic o_full;
    logic o_push;
    logic o_pop;

    assign o_full     = (o_cnt_reg == cfhash_pkg::O_CNT_W'(cfhash_pkg::O_DEPTH));
    assign empty      = (o_cnt_reg == '0);
    assign hash_value = obuf_reg[o_rd_reg];

    // Mix requests always proceed; a finish request waits for buffer room.
    assign q_pop  = !q_empty && ((q_out.op == cfhash_pkg::OP_MIX) || !o_full);
    assign o_push = q_pop && (q_out.op == cfhash_pkg::OP_FIN);
    assign o_pop  = pop && !empty;

    always_comb
    begin
        o_cnt_next = o_cnt_reg;
        if (o_push && !o_pop)
        begin
            o_cnt_next = o_cnt_reg + cfhash_pkg::O_CNT_W'(1);
        end
        else if (o_pop && !o_push)
        begin
            o_cnt_next = o_cnt_reg - cfhash_pkg::O_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_push)
        begin
            obuf_reg[o_wr_reg] <= cfhash_pkg::finish_hash(hash_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            o_wr_reg  <= '0;
            o_rd_reg  <= '0;
            o_cnt_reg <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                if (q_out.op == cfhash_pkg::OP_FIN)
                begin
                    hash_reg <= '0;
                end
                else
                begin
                    hash_reg <= cfhash_pkg::mix_byte(hash_reg, q_out.data);
                end
            end
            if (o_push)
            begin
                o_wr_reg <= o_wr_reg + cfhash_pkg::O_PTR_W'(1);
            end
            if (o_pop)
            begin
                o_rd_reg <= o_rd_reg + cfhash_pkg::O_PTR_W'(1);
            end
            o_cnt_reg <= o_cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/case_folded_one_at_a_time_hash_unit.sv @@
// Top level of the case-folded one-at-a-time path hash unit.
//
//   Channel   Ports                           Direction  Transfer
//   -------   -----------------------------   ---------  --------------------------
//   input     push, full, char_byte[7:0]      in         push high and full low
//   result    pop, empty, hash_value[31:0]    out        pop high and empty low
//
// The unit takes one byte request per cycle while full is low. The front end
// is combinational and writes the command queue at the edge that accepts the
// byte; the back end pops it and updates the running hash with an add,
// shift-add and xor-shift. A terminating zero byte passes through the command
// queue and the result buffer before its hash shows on hash_value. Reset is
// asynchronous and active low; it clears the quoting state, the running hash
// and both queues. A stalled result side fills the two-entry result buffer,
// then the four-entry command queue, and only then raises full.
`default_nettype none

module case_folded_one_at_a_time_hash_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  char_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      hash_value
);

    // Command path between the front end and the back end.
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    cfhash_pkg::cmd_t q_in;
    cfhash_pkg::cmd_t q_out;

    // The front end stalls only when the command queue is full.
    assign full = q_full;

    // The front end folds case, maps backslash to slash and drops the bytes
    // that the quoting rules ignore, so only mix and finish requests queue up.
    cfhash_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_byte (char_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in)
    );

    cfhash_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_in    (q_in),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_out   (q_out),
        .q_empty (q_empty)
    );

    // The back end owns the running hash and buffers finished results.
    cfhash_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_out      (q_out),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value)
    );

`ifndef SYNTH
    // Every accepted terminator must become a finish request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && char_byte == cfhash_pkg::CH_NUL)
            |-> (q_push && q_in.op == cfhash_pkg::OP_FIN))
        else $error("terminator did not issue a finish request");

    // A result can appear only after a finish request leaves the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !(q_pop && q_out.op == cfhash_pkg::OP_FIN)) |=> empty)
        else $error("result appeared without a finish request");

    // The queue stays full while the back end takes nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !q_pop) |=> full)
        else $error("command queue lost an entry while stalled");
`endif

endmodule

`default_nettype wire

@@ tb/tb_case_folded_one_at_a_time_hash_unit.sv @@
// Self-checking testbench for the case-folded one-at-a-time path hash unit.
module tb_case_folded_one_at_a_time_hash_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // The run is cut off here if it hangs.
    localparam int CYCLE_LIMIT = 200000;
    // Long hold-off of the result side used to back the unit up until full rises.
    localparam int HOLD_CYCLES = 120;
    // Cycles left after the last hash arrives, so that a stray extra result is caught.
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;
    localparam int DIRECTED_COUNT = 27;

    // One row of the directed table. When pinned is set, the digest column is
    // the hash that the string must produce; otherwise the predictor supplies it.
    typedef struct packed {
        logic [7:0]  ch;
        logic        pinned;
        logic [31:0] digest;
    } path_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  char_byte = 8'h00;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [31:0] hash_value;

    // A typed-in expectation travels with the request it belongs to.
    logic        pinned_valid = 1'b0;
    logic [31:0] pinned_hash = 32'h0;

    // Idle mix of each side, in percent of cycles.
    int unsigned push_idle_pct = 0;
    int unsigned pop_idle_pct = 0;
    logic        hold_request = 1'b0;

    // Predictor state: the hash of the string so far and its quoting status.
    logic [31:0] running_digest = 32'h0;
    logic        at_path_start = 1'b1;
    logic        quoted_path = 1'b0;
    logic        quote_closed = 1'b0;

    logic [31:0] pending_hashes [$];
    int          hash_errors = 0;
    int          bytes_offered = 0;
    int          bytes_taken = 0;
    int          hashes_checked = 0;
    int          full_stall_cycles = 0;

    path_row_t directed_rows [0:DIRECTED_COUNT-1] = '{
        // An empty string straight after reset hashes to zero.
        '{cfhash_pkg::CH_NUL, 1'b1, 32'h0},
        // A lone opening quote is skipped, so nothing is mixed.
        '{cfhash_pkg::CH_QUOTE, 1'b0, 32'h0}, '{cfhash_pkg::CH_NUL, 1'b1, 32'h0},
        // A quote pair closes at once; the letter after it is ignored.
        '{cfhash_pkg::CH_QUOTE, 1'b0, 32'h0}, '{cfhash_pkg::CH_QUOTE, 1'b0, 32'h0},
        '{cfhash_pkg::CH_UPPER_A, 1'b0, 32'h0}, '{cfhash_pkg::CH_NUL, 1'b1, 32'h0},
        // Both ends of the folded range, the codes just outside it, and a backslash.
        '{cfhash_pkg::CH_UPPER_A, 1'b0, 32'h0}, '{cfhash_pkg::CH_UPPER_Z, 1'b0, 32'h0},
        '{8'h40, 1'b0, 32'h0}, '{8'h5B, 1'b0, 32'h0},
        '{cfhash_pkg::CH_BACKSLASH, 1'b0, 32'h0}, '{cfhash_pkg::CH_NUL, 1'b0, 32'h0},
        // Extremes of the signed byte: all ones, most negative, most positive, one.
        '{8'hFF, 1'b0, 32'h0}, '{8'h80, 1'b0, 32'h0},
        '{8'h7F, 1'b0, 32'h0}, '{8'h01, 1'b0, 32'h0}, '{cfhash_pkg::CH_NUL, 1'b0, 32'h0},
        // A quote in an unquoted string is mixed like any other byte.
        '{8'h61, 1'b0, 32'h0}, '{cfhash_pkg::CH_QUOTE, 1'b0, 32'h0},
        '{8'h62, 1'b0, 32'h0}, '{cfhash_pkg::CH_NUL, 1'b0, 32'h0},
        // Quoted string: body is mixed, the closing quote and what follows are not.
        '{cfhash_pkg::CH_QUOTE, 1'b0, 32'h0}, '{8'h78, 1'b0, 32'h0},
        '{cfhash_pkg::CH_QUOTE, 1'b0, 32'h0}, '{8'h51, 1'b0, 32'h0},
        '{cfhash_pkg::CH_NUL, 1'b0, 32'h0}
    };

    case_folded_one_at_a_time_hash_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_byte  (char_byte),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Predictor: folds and mixes one path byte into the running hash, or drops
    // it as the quoting rules say. On the terminating zero it applies the final
    // avalanche, hands back the digest and returns to the start-of-string state.
    task automatic absorb_path_byte(input logic [7:0] b, output logic done,
                                    output logic [31:0] digest);
        logic [7:0]  folded;
        logic [31:0] h;
        done = 1'b0;
        digest = 32'h0;
        if (b == cfhash_pkg::CH_NUL)
        begin
            h = running_digest;
            h = h + (h << 3);
            h = h ^ (h >> 11);
            digest = h + (h << 15);
            done = 1'b1;
            running_digest = 32'h0;
            at_path_start = 1'b1;
            quoted_path = 1'b0;
            quote_closed = 1'b0;
        end
        else if (at_path_start && b == cfhash_pkg::CH_QUOTE)
        begin
            // An opening quote is never mixed; it only switches to quoted mode.
            at_path_start = 1'b0;
            quoted_path = 1'b1;
        end
        else
        begin
            at_path_start = 1'b0;
            if (quote_closed)
            begin
                // Everything after the closing quote is dropped until the terminator.
            end
            else if (quoted_path && b == cfhash_pkg::CH_QUOTE)
            begin
                quote_closed = 1'b1;
            end
            else
            begin
                folded = b;
                if (folded >= cfhash_pkg::CH_UPPER_A && folded <= cfhash_pkg::CH_UPPER_Z)
                    folded = folded + cfhash_pkg::CASE_OFFSET;
                else if (folded == cfhash_pkg::CH_BACKSLASH)
                    folded = cfhash_pkg::CH_SLASH;
                // The byte is signed, so it is sign-extended before the add.
                h = running_digest + {{24{folded[7]}}, folded};
                h = h + (h << 10);
                running_digest = h ^ (h >> 6);
            end
        end
    endtask

    task automatic report_hash_error(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
        if (hash_errors < REPORT_LIMIT)
            $display("[%0t] %s: expected %08h, got %08h", $time, what, want, got);
        hash_errors++;
    endtask

    // Watches both handshakes at every rising edge. Inputs are driven with
    // nonblocking assignments and the unit's outputs change the same way, so
    // the values read here are the ones that were stable before the edge.
    always @(posedge clk)
    begin : scoreboard
        logic        done;
        logic [31:0] digest;
        logic [31:0] want;
        if (rst_n)
        begin
            if (push && full)
                full_stall_cycles++;
            if (push && !full)
            begin
                bytes_taken++;
                absorb_path_byte(char_byte, done, digest);
                if (done)
                    pending_hashes.push_back(pinned_valid ? pinned_hash : digest);
            end
            if (pop && !empty)
            begin
                if (pending_hashes.size() == 0)
                begin
                    report_hash_error("hash with no request waiting", 32'h0, hash_value);
                end
                else
                begin
                    want = pending_hashes.pop_front();
                    hashes_checked++;
                    if (hash_value !== want)
                        report_hash_error("hash_value mismatch", want, hash_value);
                end
            end
        end
    end

    // Result side. It pops at random by the current idle mix, and once, when
    // asked, holds off for a long stretch so that both internal queues fill
    // and the unit has to raise full.
    initial
    begin : result_drain
        logic hold_served;
        hold_served = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d hashes still expected",
                 CYCLE_LIMIT, pending_hashes.size());
        $display("FAIL");
        $finish;
    end

    // Offers one byte request and holds it until the unit takes it. Afterwards
    // the input may go idle for some cycles, with junk on the data lines.
    task automatic offer_byte(input logic [7:0] b, input logic has_pin,
                              input logic [31:0] pin);
        push <= 1'b1;
        char_byte <= b;
        pinned_valid <= has_pin;
        pinned_hash <= pin;
        bytes_offered++;
        @(posedge clk);
        while (full)
            @(posedge clk);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            char_byte <= 8'($urandom_range(255));
            @(posedge clk);
        end
    endtask

    // Random path strings until the byte budget is reached. Most strings are
    // short; when max_len exceeds 12, about one in ten is long. The content leans
    // on the bytes that matter here: capitals, backslashes, quotes and high bytes.
    task automatic offer_random_paths(input int byte_target, input int max_len);
        int          len;
        int unsigned pick;
        logic [7:0]  c;
        while (bytes_offered < byte_target)
        begin
            if (max_len > 12 && $urandom_range(9) == 0)
                len = $urandom_range(64, 20);
            else
                len = $urandom_range(max_len);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(99);
                if (i == 0 && $urandom_range(3) == 0)
                    c = cfhash_pkg::CH_QUOTE;
                else if (pick < 30)
                    c = 8'($urandom_range(8'h7A, 8'h61));
                else if (pick < 50)
                    c = 8'($urandom_range(cfhash_pkg::CH_UPPER_Z, cfhash_pkg::CH_UPPER_A));
                else if (pick < 58)
                    c = ($urandom_range(1) == 1) ? cfhash_pkg::CH_BACKSLASH
                                                 : cfhash_pkg::CH_SLASH;
                else if (pick < 66)
                    c = cfhash_pkg::CH_QUOTE;
                else if (pick < 78)
                    c = 8'($urandom_range(255, 128));
                else
                    c = 8'($urandom_range(255, 1));
                offer_byte(c, 1'b0, 32'h0);
            end
            offer_byte(cfhash_pkg::CH_NUL, 1'b0, 32'h0);
        end
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings first, with both sides running freely.
        for (int r = 0; r < DIRECTED_COUNT; r++)
            offer_byte(directed_rows[r].ch, directed_rows[r].pinned, directed_rows[r].digest);

        // The result side idles more often than the input side.
        push_idle_pct = 38;
        pop_idle_pct <= 45;
        offer_random_paths(270, 16);

        // Now the other way round.
        push_idle_pct = 45;
        pop_idle_pct <= 38;
        offer_random_paths(510, 16);

        // Neither side idles. The result side first holds off for a long
        // stretch while short strings keep coming, so the unit backs up.
        push_idle_pct = 0;
        pop_idle_pct <= 0;
        hold_request <= 1'b1;
        offer_random_paths(bytes_offered + 36, 2);
        offer_random_paths(750, 16);

        push <= 1'b0;
        @(posedge clk);
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d path bytes and %0d checked hashes;", bytes_taken,
                 hashes_checked);
        $display("input held off by full for %0d cycles; directed quoting and folding cases,",
                 full_stall_cycles);
        $display("then random paths under three idle mixes.");
        if (hash_errors == 0 && pending_hashes.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("%0d hash errors, %0d hashes never arrived", hash_errors,
                     pending_hashes.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
